// File: rtl/core/vkvfl_pkg.sv
// Shared types and constants for the versioned key/value floor lookup.
`default_nettype none

package vkvfl_pkg;

  localparam int KEY_ID_W  = 4;
  localparam int TIME_W    = 31;
  localparam int OUT_VAL_W = 32;
  localparam int MAX_KEYS  = 1 << KEY_ID_W;

  localparam logic OP_SET = 1'b0;
  localparam logic OP_GET = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/vkvfl_entry_ram.sv
// Entry store: one write port, one registered read port.
`default_nettype none

module vkvfl_entry_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 63,
  parameter int DEPTH  = 1024
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/versioned_key_value_floor_lookup.sv
// Top level: per-key timestamped entry lists with binary-search floor lookup.
//
//  channel  | ports                                                   | flow control
//  ---------+---------------------------------------------------------+-------------------
//  input    | start, in_operation, in_key_id, in_timestamp, in_value_in | start && !busy
//  result   | out_valid, out_found, out_value_out, out_full_error      | strobe, no stall
//
// Set: busy stays low, result strobes on the next cycle.
// Get: busy while searching, P = probes <= clog2(count+1)
//   (at most 7 for 64 entries); one probe per cycle through the entry RAM read port.
// Reset clears the per-key counts and the control state; the entry RAM holds no reset state.
// Results cannot be stalled: each is shown for exactly one cycle.
`default_nettype none

module versioned_key_value_floor_lookup
  import vkvfl_pkg::*;
#(
  parameter int NUM_KEYS        = 16,
  parameter int ENTRIES_PER_KEY = 64,
  parameter int VALUE_BITS      = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_operation,
  input  wire logic [KEY_ID_W-1:0]  in_key_id,
  input  wire logic [TIME_W-1:0]    in_timestamp,
  input  wire logic [OUT_VAL_W-1:0] in_value_in,
  output logic                      out_valid,
  output logic                      out_found,
  output logic [OUT_VAL_W-1:0]      out_value_out,
  output logic                      out_full_error
);

  localparam int KEYS_USED = (NUM_KEYS < MAX_KEYS) ? NUM_KEYS : MAX_KEYS;
  localparam int KEY_W     = (KEYS_USED > 1) ? $clog2(KEYS_USED) : 1;
  localparam int IDX_W     = (ENTRIES_PER_KEY > 1) ? $clog2(ENTRIES_PER_KEY) : 1;
  localparam int CNT_W     = $clog2(ENTRIES_PER_KEY + 1);
  localparam int ADDR_W    = KEY_W + IDX_W;
  localparam int DEPTH     = KEYS_USED * (1 << IDX_W);
  localparam int DATA_W    = TIME_W + VALUE_BITS;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]      counts_r [KEYS_USED];
  logic [KEY_W-1:0]      key_r;
  logic [TIME_W-1:0]     ts_r;
  logic [CNT_W-1:0]      lo_r, hi_r;
  logic [IDX_W-1:0]      mid_r;
  logic                  pend_r;
  logic                  found_r;
  logic [VALUE_BITS-1:0] val_r;

  logic                  out_valid_r, out_found_r, out_full_r;
  logic [OUT_VAL_W-1:0]  out_value_r;

  logic                  accept, key_ok, is_full;
  logic [CNT_W-1:0]      cnt_in;
  logic [KEY_W-1:0]      key_idx;

  logic [DATA_W-1:0]     rd_data;
  logic [TIME_W-1:0]     rd_time;
  logic [VALUE_BITS-1:0] rd_val;

  logic [CNT_W-1:0]      lo_s, hi_s, mid_calc;
  logic [IDX_W-1:0]      mid_s;
  logic                  found_s, more;
  logic [VALUE_BITS-1:0] val_s;

  logic                  wr_en, rd_en, set_done, get_done;
  logic [ADDR_W-1:0]     wr_addr, rd_addr;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign key_idx = in_key_id[KEY_W-1:0];
  assign key_ok  = ({1'b0, in_key_id} < (KEY_ID_W + 1)'(KEYS_USED));
  assign cnt_in  = counts_r[key_idx];
  assign is_full = (cnt_in == CNT_W'(ENTRIES_PER_KEY));

  assign rd_time = rd_data[DATA_W-1 -: TIME_W];
  assign rd_val  = rd_data[VALUE_BITS-1:0];

  // Fold in the probe that just returned, then pick the next midpoint.
  always_comb begin
    lo_s    = lo_r;
    hi_s    = hi_r;
    found_s = found_r;
    val_s   = val_r;
    if (pend_r) begin
      if (ts_r >= rd_time) begin
        found_s = 1'b1;
        val_s   = rd_val;
        lo_s    = CNT_W'(mid_r) + CNT_W'(1);
      end else begin
        hi_s = CNT_W'(mid_r);
      end
    end
    more     = (lo_s < hi_s);
    mid_calc = lo_s + ((hi_s - lo_s - CNT_W'(1)) >> 1);
    mid_s    = mid_calc[IDX_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_operation == OP_GET) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!more) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    set_done = 1'b0;
    get_done = 1'b0;
    case (state_r)
      ST_IDLE: begin
        set_done = accept && (in_operation == OP_SET);
        wr_en    = set_done && key_ok && !is_full;
      end
      ST_SEARCH: begin
        rd_en    = more;
        get_done = !more;
      end
      default: ;
    endcase
  end

  assign wr_addr = {key_idx, cnt_in[IDX_W-1:0]};
  assign rd_addr = {key_r, mid_s};

  vkvfl_entry_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W),
    .DEPTH  (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({in_timestamp, VALUE_BITS'(in_value_in)}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < KEYS_USED; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= set_done || get_done;
      if (wr_en) begin
        counts_r[key_idx] <= cnt_in + CNT_W'(1);
      end
      if (accept) begin
        pend_r <= 1'b0;
      end else if (state_r == ST_SEARCH) begin
        pend_r <= more;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r   <= key_idx;
      ts_r    <= in_timestamp;
      lo_r    <= '0;
      hi_r    <= key_ok ? cnt_in : '0;
      found_r <= 1'b0;
      val_r   <= '0;
    end else if (state_r == ST_SEARCH) begin
      lo_r    <= lo_s;
      hi_r    <= hi_s;
      mid_r   <= mid_s;
      found_r <= found_s;
      val_r   <= val_s;
    end
    if (set_done) begin
      out_found_r <= 1'b0;
      out_value_r <= '0;
      out_full_r  <= key_ok && is_full;
    end else if (get_done) begin
      out_found_r <= found_s;
      out_value_r <= OUT_VAL_W'(val_s);
      out_full_r  <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_value_out  = out_value_r;
  assign out_full_error = out_full_r;

endmodule

`default_nettype wire

// File: rtl/core/vkvfl_checker.sv
// Port-level checks for the floor lookup, bound to the top level.
`default_nettype none

module vkvfl_checker
  import vkvfl_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 out_valid,
  input wire logic                 out_found,
  input wire logic [OUT_VAL_W-1:0] out_value_out,
  input wire logic                 out_full_error
);

  // every transfer either answers next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("transfer neither answered nor in progress");

  // end of a lookup always comes with its result strobe
  a_search_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("lookup finished without result");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_full_error))
    else $error("found and full_error both set");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_value_out == '0)
    else $error("nonzero value without a hit");

  // a dropped set is answered right after an idle-cycle transfer
  a_full_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_error |-> !$past(busy) && $past(start))
    else $error("full_error not tied to a set transfer");

endmodule

bind versioned_key_value_floor_lookup vkvfl_checker u_vkvfl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_found      (out_found),
  .out_value_out  (out_value_out),
  .out_full_error (out_full_error)
);

`default_nettype wire
